/* src/wsfd_pkg.sv */
`default_nettype none
package wsfd_pkg;

  // Width of the length and size result fields.
  localparam int unsigned OUT_LEN_W = 64;

  // Seven-bit length codes that announce an extended length.
  localparam logic [6:0] LEN16_CODE = 7'd126;
  localparam logic [6:0] LEN64_CODE = 7'd127;

  // Number of extended length bytes and masking key bytes.
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [2:0] KEY_BYTES   = 3'd4;

  // Result kinds.
  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef struct packed {
    logic                 item_kind;
    logic                 final_fragment;
    logic [3:0]           frame_opcode;
    logic                 was_masked;
    logic [OUT_LEN_W-1:0] payload_len;
    logic [7:0]           payload_byte;
    logic                 frame_last;
    logic [OUT_LEN_W-1:0] frame_total;
  } result_t;

endpackage
`default_nettype wire

/* src/wsfd_parser.sv */
`default_nettype none
module wsfd_parser #(
  parameter int unsigned LENGTH_BITS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [7:0]        stream_byte,
  output logic                   res_valid,
  output wsfd_pkg::result_t      res
);

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_PAY  = 3'd4
  } phase_t;

  phase_t                 phase_r,  phase_nxt;
  logic                   fin_r,    fin_nxt;
  logic [3:0]             opcode_r, opcode_nxt;
  logic                   mask_r,   mask_nxt;
  logic [LENGTH_BITS-1:0] length_r, length_nxt;
  logic [3:0]             ext_r,    ext_nxt;
  logic [31:0]            key_r,    key_nxt;
  logic [2:0]             seen_r,   seen_nxt;
  logic [LENGTH_BITS-1:0] index_r,  index_nxt;
  logic [wsfd_pkg::OUT_LEN_W-1:0] count_r, count_nxt;

  always_comb begin
    logic [6:0] l7;
    logic       len_done;
    logic       hdr_done;
    logic [7:0] key_byte;
    logic       last;
    phase_nxt  = phase_r;
    fin_nxt    = fin_r;
    opcode_nxt = opcode_r;
    mask_nxt   = mask_r;
    length_nxt = length_r;
    ext_nxt    = ext_r;
    key_nxt    = key_r;
    seen_nxt   = seen_r;
    index_nxt  = index_r;
    count_nxt  = count_r;
    l7         = stream_byte[6:0];
    len_done   = 1'b0;
    hdr_done   = 1'b0;
    key_byte   = 8'd0;
    last       = 1'b0;
    res_valid  = 1'b0;
    res.item_kind    = wsfd_pkg::KIND_HEADER;
    res.payload_byte = 8'd0;

    case (phase_r)
      PH_HDR1: begin
        count_nxt = count_r + 1'b1;
        mask_nxt  = stream_byte[7];
        if ((l7 == wsfd_pkg::LEN16_CODE) || (l7 == wsfd_pkg::LEN64_CODE)) begin
          ext_nxt    = (l7 == wsfd_pkg::LEN16_CODE) ? wsfd_pkg::EXT16_BYTES
                                                    : wsfd_pkg::EXT64_BYTES;
          length_nxt = '0;
          phase_nxt  = PH_EXT;
        end else begin
          length_nxt = LENGTH_BITS'(l7);
          len_done   = 1'b1;
        end
      end
      PH_EXT: begin
        count_nxt  = count_r + 1'b1;
        length_nxt = {length_r[LENGTH_BITS-9:0], stream_byte};
        ext_nxt    = ext_r - 1'b1;
        if (ext_nxt == 4'd0) begin
          len_done = 1'b1;
        end
      end
      PH_KEY: begin
        count_nxt = count_r + 1'b1;
        key_nxt   = {key_r[23:0], stream_byte};
        seen_nxt  = seen_r + 1'b1;
        if (seen_nxt == wsfd_pkg::KEY_BYTES) begin
          hdr_done = 1'b1;
        end
      end
      PH_PAY: begin
        count_nxt = count_r + 1'b1;
        case (index_r[1:0])
          2'd0:    key_byte = key_r[31:24];
          2'd1:    key_byte = key_r[23:16];
          2'd2:    key_byte = key_r[15:8];
          default: key_byte = key_r[7:0];
        endcase
        if (!mask_r) begin
          key_byte = 8'd0;
        end
        last             = ((index_r + 1'b1) == length_r);
        index_nxt        = index_r + 1'b1;
        res_valid        = 1'b1;
        res.item_kind    = wsfd_pkg::KIND_PAYLOAD;
        res.payload_byte = stream_byte ^ key_byte;
        if (last) begin
          phase_nxt = PH_HDR0;
        end
      end
      default: begin
        // First header byte; unused phase codes land here as well.
        count_nxt  = 64'd1;
        fin_nxt    = stream_byte[7];
        opcode_nxt = stream_byte[3:0];
        mask_nxt   = 1'b0;
        length_nxt = '0;
        key_nxt    = '0;
        seen_nxt   = '0;
        ext_nxt    = '0;
        index_nxt  = '0;
        phase_nxt  = PH_HDR1;
      end
    endcase

    // Once the length is known, a masked frame still needs its key.
    if (len_done) begin
      if (mask_nxt) begin
        seen_nxt  = '0;
        key_nxt   = '0;
        phase_nxt = PH_KEY;
      end else begin
        hdr_done = 1'b1;
      end
    end

    if (hdr_done) begin
      last      = (length_nxt == '0);
      index_nxt = '0;
      res_valid = 1'b1;
      phase_nxt = last ? PH_HDR0 : PH_PAY;
    end

    res.final_fragment = fin_nxt;
    res.frame_opcode   = opcode_nxt;
    res.was_masked     = mask_nxt;
    res.payload_len    = wsfd_pkg::OUT_LEN_W'(length_nxt);
    res.frame_last     = last;
    res.frame_total    = last ? count_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      fin_r    <= 1'b0;
      opcode_r <= '0;
      mask_r   <= 1'b0;
      length_r <= '0;
      ext_r    <= '0;
      key_r    <= '0;
      seen_r   <= '0;
      index_r  <= '0;
      count_r  <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      fin_r    <= fin_nxt;
      opcode_r <= opcode_nxt;
      mask_r   <= mask_nxt;
      length_r <= length_nxt;
      ext_r    <= ext_nxt;
      key_r    <= key_nxt;
      seen_r   <= seen_nxt;
      index_r  <= index_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/websocket_frame_decoder.sv */
// Path: an accepted request moves from the input register through the parser into the result register.
// Throughput: one stream byte per cycle; the single parser state update per
// byte sits between the input register and the result register. Input
// stalls only while a finished result is held by the receiver.
// Reset: synchronous, active low; the parser returns to expecting the first
// header byte and both pipeline registers are emptied.
`default_nettype none
module websocket_frame_decoder #(
  parameter int unsigned LENGTH_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel: one frame stream byte per request.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_stream_byte,
  // Result channel: a header result or an unmasked payload byte.
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_item_kind,
  output logic             out_final_fragment,
  output logic [3:0]       out_frame_opcode,
  output logic             out_was_masked,
  output logic [63:0]      out_payload_len,
  output logic [7:0]       out_payload_byte,
  output logic             out_frame_last,
  output logic [63:0]      out_frame_total
);

  // The pipeline advances unless a finished result is held by a stall.
  logic              advance;
  logic              s1_valid_r;
  logic [7:0]        s1_byte_r;
  logic              res_valid;
  wsfd_pkg::result_t res;
  logic              out_valid_r;
  wsfd_pkg::result_t out_r;

  assign advance  = !(out_valid_r && out_stall);
  // The input register still takes a request while a result waits, as long
  // as it is empty itself.
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!s1_valid_r || advance) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if ((!s1_valid_r || advance) && in_valid) begin
      s1_byte_r <= in_stream_byte;
    end
  end

  // The parser updates its state only when the byte in the input register
  // moves on to the result register.
  wsfd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_valid_r && advance),
    .stream_byte (s1_byte_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Bytes that complete no result leave the result register empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_item_kind      = out_r.item_kind;
  assign out_final_fragment = out_r.final_fragment;
  assign out_frame_opcode   = out_r.frame_opcode;
  assign out_was_masked     = out_r.was_masked;
  assign out_payload_len    = out_r.payload_len;
  assign out_payload_byte   = out_r.payload_byte;
  assign out_frame_last     = out_r.frame_last;
  assign out_frame_total    = out_r.frame_total;

endmodule
`default_nettype wire

/* src/wsfd_checker.sv */
`default_nettype none
module wsfd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [7:0]  in_stream_byte,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_item_kind,
  input wire logic        out_final_fragment,
  input wire logic [3:0]  out_frame_opcode,
  input wire logic        out_was_masked,
  input wire logic [63:0] out_payload_len,
  input wire logic [7:0]  out_payload_byte,
  input wire logic        out_frame_last,
  input wire logic [63:0] out_frame_total
);

  // A stalled request stays put until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_stream_byte))
    else $error("stalled request changed");

  // A stalled result stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload_byte)
      && $stable(out_frame_total) && $stable(out_item_kind)
      && $stable(out_final_fragment) && $stable(out_frame_opcode)
      && $stable(out_was_masked) && $stable(out_payload_len)
      && $stable(out_frame_last))
    else $error("stalled result changed");

  // A header for an empty payload closes its frame.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item_kind == wsfd_pkg::KIND_HEADER)
      && (out_payload_len == 64'd0) |-> out_frame_last)
    else $error("empty frame header not marked last");

  // The frame size is only reported on the last result.
  a_size_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_last |-> out_frame_total == 64'd0)
    else $error("frame size reported before frame end");

  // Payload bytes only exist for frames with a nonzero length.
  a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item_kind == wsfd_pkg::KIND_PAYLOAD)
      |-> out_payload_len != 64'd0)
    else $error("payload byte in zero length frame");

endmodule

bind websocket_frame_decoder wsfd_checker u_wsfd_checker (.*);
`default_nettype wire
